[rtl/core/rtwc_pkg.sv]
package rtwc_pkg;

  localparam int SPACING_W = 31;
  localparam int COUNT_W   = 16;
  localparam int TRACK_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT_D,
    ST_WAIT_E,
    ST_UPDATE,
    ST_DECIDE,
    ST_WAIT_Q,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/core/rtwc_if.sv]
interface rtwc_in_if #(parameter int COORD_WIDTH = 32);
  logic                              valid;
  logic                              ready;
  logic                              want_horizontal;
  logic signed [COORD_WIDTH-1:0]     window_low;
  logic signed [COORD_WIDTH-1:0]     window_high;
  logic [rtwc_pkg::SPACING_W-1:0]    via_pitch;
  logic                              pattern_is_horizontal;
  logic signed [COORD_WIDTH-1:0]     pattern_start;
  logic [rtwc_pkg::SPACING_W-1:0]    pattern_spacing;
  logic [rtwc_pkg::COUNT_W-1:0]      pattern_count;
  logic                              last_pattern;

  modport source (
    output valid, want_horizontal, window_low, window_high, via_pitch,
           pattern_is_horizontal, pattern_start, pattern_spacing, pattern_count,
           last_pattern,
    input  ready
  );

  modport sink (
    input  valid, want_horizontal, window_low, window_high, via_pitch,
           pattern_is_horizontal, pattern_start, pattern_spacing, pattern_count,
           last_pattern,
    output ready
  );
endinterface

interface rtwc_out_if;
  logic                           valid;
  logic                           ready;
  logic [rtwc_pkg::TRACK_W-1:0]   track_count;

  modport source (output valid, track_count, input ready);
  modport sink (input valid, track_count, output ready);
endinterface

[rtl/core/routing_track_window_counter.sv]
// Steps: a used pattern runs two divisions by its spacing (window low, then high) and
// an update; a skipped one goes straight to the decision. A last pattern adds a finish
// step, preceded in estimate mode by a via-pitch division. NW = max(COORD_WIDTH,31)+2 (34).
// One pattern is in flight at a time; its divisions share one radix-2 divider.
// A result waits in the output register while the next pattern is taken.
// Reset: synchronous, active high; clears the query sums and the output valid.
module routing_track_window_counter #(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  rtwc_in_if.sink    pattern,
  rtwc_out_if.source result
);

  localparam int SW     = rtwc_pkg::SPACING_W;
  localparam int CNT_W  = rtwc_pkg::COUNT_W;
  localparam int TW     = rtwc_pkg::TRACK_W;
  localparam int EW     = ((COORD_WIDTH > 31) ? COORD_WIDTH : 31) + 2;
  localparam int XW     = EW - COORD_WIDTH;
  localparam logic signed [EW-1:0] START_INIT =
    {{(XW+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};

  rtwc_pkg::st_t state;
  rtwc_pkg::st_t state_next;

  logic                          used_q;
  logic                          last_q;
  logic signed [COORD_WIDTH-1:0] low_q;
  logic signed [COORD_WIDTH-1:0] high_q;
  logic signed [COORD_WIDTH-1:0] start_q;
  logic [SW-1:0]                 sp_q;
  logic [SW-1:0]                 pitch_q;
  logic [CNT_W-1:0]              cnt_q;

  logic [TW-1:0]                 running;
  logic [TW-1:0]                 running_next;
  logic signed [EW-1:0]          earliest;
  logic                          seen;
  logic [EW-1:0]                 qd;
  logic [SW-1:0]                 rd;
  logic [TW-1:0]                 answer;
  logic                          out_valid;
  logic [TW-1:0]                 out_count;

  logic                          accept;
  logic                          div_start;
  logic                          finish_go;
  logic [EW-1:0]                 div_dividend;
  logic [SW-1:0]                 div_divisor;
  logic [EW-1:0]                 div_quo;
  logic [SW-1:0]                 div_rem;
  rtwc_pkg::div_stat_t           div_stat;

  logic signed [EW-1:0]          low_x;
  logic signed [EW-1:0]          high_x;
  logic signed [EW-1:0]          start_x;
  logic signed [EW-1:0]          d;
  logic signed [EW-1:0]          e;
  logic signed [EW-1:0]          e2;
  logic [EW-1:0]                 d_mag;
  logic [EW-1:0]                 e_mag;
  logic                          d_pos;
  logic                          e_pos;
  logic                          e2_pos;
  logic [EW:0]                   t;
  logic [EW:0]                   u;
  logic [EW:0]                   cnt_ext;
  logic [EW:0]                   lim;
  logic [EW:0]                   n_wide;
  logic [CNT_W-1:0]              n;
  logic [TW:0]                   sum;
  logic [SW-1:0]                 adj;
  logic signed [EW-1:0]          off;
  logic [EW-1:0]                 q_final;

  rtwc_div #(.NW(EW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign accept = pattern.valid && pattern.ready;

  assign low_x   = {{XW{low_q[COORD_WIDTH-1]}}, low_q};
  assign high_x  = {{XW{high_q[COORD_WIDTH-1]}}, high_q};
  assign start_x = {{XW{start_q[COORD_WIDTH-1]}}, start_q};
  assign d       = low_x - start_x;
  assign e       = high_x - start_x;
  assign e2      = high_x - earliest;
  assign d_pos   = !d[EW-1] && (d != '0);
  assign e_pos   = !e[EW-1] && (e != '0);
  assign e2_pos  = !e2[EW-1] && (e2 != '0);
  assign d_mag   = d[EW-1] ? EW'(-d) : d;
  assign e_mag   = e_pos ? e : '0;

  assign t       = d_pos ? ({1'b0, qd} + {{EW{1'b0}}, rd != '0}) : '0;
  assign u       = e_pos ? ({1'b0, div_quo} + {{EW{1'b0}}, div_rem != '0}) : '0;
  assign cnt_ext = {{(EW+1-CNT_W){1'b0}}, cnt_q};
  assign lim     = (u < cnt_ext) ? u : cnt_ext;
  assign n_wide  = lim - t;
  assign n       = (lim > t) ? n_wide[CNT_W-1:0] : '0;
  assign sum     = {1'b0, running} + {{(TW+1-CNT_W){1'b0}}, n};
  assign running_next = sum[TW] ? '1 : sum[TW-1:0];

  assign adj     = d_pos ? ((rd == '0) ? '0 : (sp_q - rd)) : rd;
  assign off     = low_x + signed'({{(EW-SW){1'b0}}, adj});
  assign q_final = (div_rem == '0) ? (div_quo - {{(EW-1){1'b0}}, 1'b1}) : div_quo;

  always_comb begin
    state_next = state;
    case (state)
      rtwc_pkg::ST_IDLE:   if (accept) state_next = rtwc_pkg::ST_LOAD;
      rtwc_pkg::ST_LOAD:   state_next = used_q ? rtwc_pkg::ST_WAIT_D : rtwc_pkg::ST_DECIDE;
      rtwc_pkg::ST_WAIT_D: if (div_stat.done) state_next = rtwc_pkg::ST_WAIT_E;
      rtwc_pkg::ST_WAIT_E: if (div_stat.done) state_next = rtwc_pkg::ST_UPDATE;
      rtwc_pkg::ST_UPDATE: state_next = rtwc_pkg::ST_DECIDE;
      rtwc_pkg::ST_DECIDE: begin
        if (!last_q) begin
          state_next = rtwc_pkg::ST_IDLE;
        end else if ((pitch_q != '0) && seen && e2_pos) begin
          state_next = rtwc_pkg::ST_WAIT_Q;
        end else begin
          state_next = rtwc_pkg::ST_FINISH;
        end
      end
      rtwc_pkg::ST_WAIT_Q: if (div_stat.done) state_next = rtwc_pkg::ST_FINISH;
      rtwc_pkg::ST_FINISH: if (finish_go) state_next = rtwc_pkg::ST_IDLE;
      default:             state_next = rtwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pattern.ready = 1'b0;
    div_start     = 1'b0;
    finish_go     = 1'b0;
    div_dividend  = d_mag;
    div_divisor   = sp_q;
    case (state)
      rtwc_pkg::ST_IDLE:   pattern.ready = !rst;
      rtwc_pkg::ST_LOAD:   div_start = used_q;
      rtwc_pkg::ST_WAIT_D: begin
        div_dividend = e_mag;
        div_start    = div_stat.done;
      end
      rtwc_pkg::ST_DECIDE: begin
        div_dividend = e2;
        div_divisor  = pitch_q;
        div_start    = last_q && (pitch_q != '0) && seen && e2_pos;
      end
      rtwc_pkg::ST_FINISH: finish_go = !out_valid || result.ready;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      used_q  <= (pattern.pattern_is_horizontal != pattern.want_horizontal) &&
                 (pattern.pattern_spacing != '0);
      last_q  <= pattern.last_pattern;
      low_q   <= pattern.window_low;
      high_q  <= pattern.window_high;
      start_q <= pattern.pattern_start;
      sp_q    <= pattern.pattern_spacing;
      pitch_q <= pattern.via_pitch;
      cnt_q   <= pattern.pattern_count;
    end
    if ((state == rtwc_pkg::ST_WAIT_D) && div_stat.done) begin
      qd <= div_quo;
      rd <= div_rem;
    end
    if (state == rtwc_pkg::ST_DECIDE) begin
      answer <= (pitch_q == '0) ? running : '0;
    end else if ((state == rtwc_pkg::ST_WAIT_Q) && div_stat.done) begin
      answer <= q_final[TW-1:0];
    end
    if (finish_go) begin
      out_count <= answer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      earliest  <= START_INIT;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == rtwc_pkg::ST_UPDATE) begin
        running <= running_next;
        if (!seen || (off < earliest)) begin
          earliest <= off;
        end
        seen <= 1'b1;
      end
      if (finish_go) begin
        running   <= '0;
        earliest  <= START_INIT;
        seen      <= 1'b0;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.track_count = out_count;

endmodule

[rtl/core/rtwc_div.sv]
module rtwc_div #(
  parameter int NW = 34
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [NW-1:0]                  dividend,
  input  logic [rtwc_pkg::SPACING_W-1:0] divisor,
  output logic [NW-1:0]                  quotient,
  output logic [rtwc_pkg::SPACING_W-1:0] remainder,
  output rtwc_pkg::div_stat_t            stat
);

  localparam int SW   = rtwc_pkg::SPACING_W;
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [NW-1:0]   quo;
  logic [SW-1:0]   rem;
  logic [SW-1:0]   dvs;
  logic [SW:0]     shifted;
  logic [SW+1:0]   diff;
  logic            neg;

  assign shifted = {rem, quo[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign neg     = diff[SW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ~neg};
      rem <= neg ? shifted[SW-1:0] : diff[SW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/core/rtwc_checker.sv]
module rtwc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rtwc_pkg::TRACK_W-1:0] out_count
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready high right after a pattern transaction");

  a_no_result_midquery: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_last && !out_valid) |=> !out_valid)
    else $error("result raised by a pattern that is not the last of a query");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
    else $error("stalled result transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind routing_track_window_counter rtwc_checker u_rtwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pattern.valid),
  .in_ready  (pattern.ready),
  .in_last   (pattern.last_pattern),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_count (result.track_count)
);
